### design/f32as_pkg.sv
// ----------------------------------------------------------------------------
// f32as_pkg
// Shared constants and types for the single-precision adder/subtractor.
// ----------------------------------------------------------------------------
package f32as_pkg;

	localparam int unsigned FRAC_W = 23;
	localparam int unsigned EXP_W  = 8;
	localparam int unsigned SIG_W  = 24;	// fraction plus hidden bit
	localparam int unsigned SUM_W  = 25;	// significand plus carry
	localparam int unsigned LZC_W  = 5;
	localparam logic [EXP_W-1:0] ALIGN_LIMIT = 8'd25;

	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_SUB = 1'b1
	} cmd_t;

	// leading-zero count of a 24-bit significand (value is non-zero)
	function automatic logic [LZC_W-1:0] lzc24(input logic [SIG_W-1:0] v);
		logic [LZC_W-1:0] n;
		logic             found;
		n     = '0;
		found = 1'b0;
		for (int i = SIG_W - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = LZC_W'(SIG_W - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

### design/f32as_if.sv
// ----------------------------------------------------------------------------
// f32as_in_if / f32as_out_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface f32as_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] a_bits;
	logic [31:0] b_bits;
	modport source (output valid, command, a_bits, b_bits, input ready);
	modport sink   (input valid, command, a_bits, b_bits, output ready);
endinterface

interface f32as_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;
	modport source (output valid, result_bits, input ready);
	modport sink   (input valid, result_bits, output ready);
endinterface

### design/float32_add_sub.sv
// Four register stages from input accept to result valid; one item per cycle while the output is not stalled.
// Stages: unpack/compare, align, add/subtract with leading-zero count, pack.
// A stall on the output freezes every full stage whose successors are all full.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// float32_add_sub
// Four-stage pipelined IEEE-754 single adder/subtractor, truncating.
// ----------------------------------------------------------------------------
module float32_add_sub (
	input  logic              clk,
	input  logic              arst_n,
	f32as_in_if.sink          in_ch,
	f32as_out_if.source       out_ch
);

	localparam int unsigned EW = f32as_pkg::EXP_W;
	localparam int unsigned SW = f32as_pkg::SIG_W;
	localparam int unsigned UW = f32as_pkg::SUM_W;
	localparam int unsigned LW = f32as_pkg::LZC_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// a stage advances when it is empty or its successor moves
	assign en_s4 = !v_s4 || out_ch.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;

	// stage 1: unpack, pick the larger operand
	logic          sb_s1, same_s1;
	logic [EW-1:0] eb_s1, dist_s1;
	logic [SW-1:0] mb_s1, ms_s1;

	logic          sx, sy;
	logic [EW-1:0] ex, ey;
	logic [SW-1:0] mx, my;
	logic          x_big;

	always_comb begin
		sx = in_ch.a_bits[31];
		sy = in_ch.b_bits[31] ^ (f32as_pkg::cmd_t'(in_ch.command) == f32as_pkg::CMD_SUB);
		ex = in_ch.a_bits[30:23];
		ey = in_ch.b_bits[30:23];
		mx = {1'b1, in_ch.a_bits[22:0]};
		my = {1'b1, in_ch.b_bits[22:0]};
		x_big = (ex > ey) || (ex == ey && mx >= my);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			same_s1 <= (sx == sy);
			sb_s1   <= x_big ? sx : sy;
			eb_s1   <= x_big ? ex : ey;
			mb_s1   <= x_big ? mx : my;
			ms_s1   <= x_big ? my : mx;
			dist_s1 <= x_big ? ex - ey : ey - ex;
		end
	end

	// stage 2: align the smaller significand
	logic          sb_s2, same_s2;
	logic [EW-1:0] eb_s2;
	logic [SW-1:0] mb_s2, ms_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			same_s2 <= same_s1;
			sb_s2   <= sb_s1;
			eb_s2   <= eb_s1;
			mb_s2   <= mb_s1;
			ms_s2   <= (dist_s1 >= f32as_pkg::ALIGN_LIMIT) ? '0 : ms_s1 >> dist_s1[4:0];
		end
	end

	// stage 3: add or subtract, count leading zeros
	logic          sb_s3, same_s3, zero_s3;
	logic [EW-1:0] eb_s3;
	logic [UW-1:0] sum_s3;
	logic [LW-1:0] lz_s3;
	logic [UW-1:0] sum_c;

	always_comb begin
		if (same_s2) sum_c = {1'b0, mb_s2} + {1'b0, ms_s2};
		else         sum_c = {1'b0, mb_s2} - {1'b0, ms_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			same_s3 <= same_s2;
			sb_s3   <= sb_s2;
			eb_s3   <= eb_s2;
			sum_s3  <= sum_c;
			zero_s3 <= (sum_c == '0);
			lz_s3   <= f32as_pkg::lzc24(sum_c[SW-1:0]);
		end
	end

	// stage 4: normalise and pack
	logic [31:0]   res_s4;
	logic [EW-1:0] exp_c;
	logic [SW-1:0] sig_c;

	always_comb begin
		if (same_s3) begin
			if (sum_s3[UW-1]) begin
				sig_c = sum_s3[UW-1:1];
				exp_c = eb_s3 + 1'b1;
			end else begin
				sig_c = sum_s3[SW-1:0];
				exp_c = eb_s3;
			end
		end else begin
			sig_c = sum_s3[SW-1:0] << lz_s3;
			exp_c = eb_s3 - EW'(lz_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			if (!same_s3 && zero_s3) res_s4 <= '0;
			else                     res_s4 <= {sb_s3, exp_c, sig_c[SW-2:0]};
		end
	end

	assign out_ch.valid       = v_s4;
	assign out_ch.result_bits = res_s4;

endmodule
